>>> rtl/slip_pkg.sv
// Package with the shared codes and types of the SLIP frame encoder.
package slip_pkg;

   localparam logic [7:0] FRAME_MARK = 8'd192;
   localparam logic [7:0] ESC_MARK   = 8'd219;
   localparam logic [7:0] ESC_FRAME  = 8'd220;
   localparam logic [7:0] ESC_ESC    = 8'd221;
   localparam logic [7:0] ACK_CODE   = 8'd69;
   localparam logic [7:0] NACK_CODE  = 8'd96;
   localparam logic [7:0] LOW_MASK   = 8'hFF;

   localparam int ENTRY_COUNT = 7;
   localparam int ENTRY_BITS  = 3;

   typedef enum logic [1:0] {
      OP_START   = 2'd0,
      OP_PAYLOAD = 2'd1,
      OP_ACK     = 2'd2,
      OP_NACK    = 2'd3
   } op_type;

   typedef struct packed {
      logic [7:0] value;
      logic       escape;
      logic       closing;
   } entry_type;

endpackage

>>> rtl/slip_frame_encoder.sv
// The first line byte of a transaction passes through the item register, then the output register.
// The emitter sends an item's line bytes one after another: one or two for a payload byte,
// four to seven for one that closes its frame, four to twelve for a start.
// Single-byte items are taken in every cycle while the output is not stalled; the emitter sets the sustained rate.
// Reset is synchronous and active high: no frame open, counters cleared, output empty.
module slip_frame_encoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // channel_id [7:0], payload_length [23:8], data_byte [31:24]
   input  logic [1:0]  req_tuser,   // operation [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // line_byte [7:0]
   output logic        rsp_tlast,
   output logic        rsp_tuser    // frame_closed [0]
);
   import slip_pkg::*;

   logic                  frame_open_ff, frame_open_in;
   logic [15:0]           remaining_ff, remaining_in;
   logic [15:0]           sum_ff, sum_in;

   logic                  item_valid_ff, item_valid_in;
   entry_type             entry_ff [ENTRY_COUNT];
   entry_type             entry_in [ENTRY_COUNT];
   logic [ENTRY_BITS-1:0] count_ff, count_in;
   logic [ENTRY_BITS-1:0] idx_ff, idx_in;
   logic                  half_ff, half_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_byte_ff, rsp_byte_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_close_ff, rsp_close_in;

   op_type                op;
   logic [7:0]            channel;
   logic [15:0]           length;
   logic [7:0]            data_byte;
   logic [15:0]           start_sum;
   logic [15:0]           payload_sum;
   logic [15:0]           remaining_dec;
   logic                  accept;
   logic                  produce;

   entry_type             cur;
   logic                  needs_esc;
   logic                  entry_done;
   logic                  item_done;
   logic                  load_out;

   assign op        = op_type'(req_tuser);
   assign channel   = req_tdata[7:0];
   assign length    = req_tdata[23:8];
   assign data_byte = req_tdata[31:24];

   assign start_sum     = {8'd0, channel} + {8'd0, length[15:8]} + {8'd0, length[7:0]};
   assign payload_sum   = sum_ff + {8'd0, data_byte};
   assign remaining_dec = remaining_ff - 16'd1;

   assign cur        = entry_ff[idx_ff];
   assign needs_esc  = cur.escape && (cur.value == FRAME_MARK || cur.value == ESC_MARK);
   assign entry_done = !needs_esc || half_ff;
   assign item_done  = entry_done && (idx_ff == count_ff - ENTRY_BITS'(1));
   assign load_out   = item_valid_ff && (!rsp_valid_ff || rsp_tready);

   assign req_tready = !item_valid_ff || (load_out && item_done);
   assign accept     = req_tvalid && req_tready;
   assign produce    = accept && !(op == OP_PAYLOAD && !frame_open_ff);

   always_comb begin
      frame_open_in = frame_open_ff;
      remaining_in  = remaining_ff;
      sum_in        = sum_ff;
      count_in      = count_ff;
      for (int i = 0; i < ENTRY_COUNT; i++) begin
         entry_in[i] = '0;
      end
      unique case (op)
         OP_START: begin
            entry_in[0] = '{value: FRAME_MARK,      escape: 1'b0, closing: 1'b0};
            entry_in[1] = '{value: channel,         escape: 1'b1, closing: 1'b0};
            entry_in[2] = '{value: length[15:8],    escape: 1'b1, closing: 1'b0};
            entry_in[3] = '{value: length[7:0],     escape: 1'b1, closing: 1'b0};
            entry_in[4] = '{value: start_sum[15:8], escape: 1'b1, closing: 1'b0};
            entry_in[5] = '{value: start_sum[7:0] & LOW_MASK, escape: 1'b1, closing: 1'b0};
            entry_in[6] = '{value: FRAME_MARK,      escape: 1'b0, closing: 1'b1};
            sum_in = start_sum;
            if (length == 16'd0) begin
               count_in      = ENTRY_BITS'(7);
               frame_open_in = 1'b0;
               remaining_in  = 16'd0;
            end else begin
               count_in      = ENTRY_BITS'(4);
               frame_open_in = 1'b1;
               remaining_in  = length;
            end
         end
         OP_PAYLOAD: begin
            entry_in[0] = '{value: data_byte,         escape: 1'b1, closing: 1'b0};
            entry_in[1] = '{value: payload_sum[15:8], escape: 1'b1, closing: 1'b0};
            entry_in[2] = '{value: payload_sum[7:0],  escape: 1'b1, closing: 1'b0};
            entry_in[3] = '{value: FRAME_MARK,        escape: 1'b0, closing: 1'b1};
            if (frame_open_ff) begin
               sum_in = payload_sum;
               if (remaining_dec == 16'd0) begin
                  count_in      = ENTRY_BITS'(4);
                  frame_open_in = 1'b0;
                  remaining_in  = 16'd0;
               end else begin
                  count_in     = ENTRY_BITS'(1);
                  remaining_in = remaining_dec;
               end
            end
         end
         OP_ACK: begin
            entry_in[0] = '{value: ACK_CODE, escape: 1'b1, closing: 1'b0};
            count_in    = ENTRY_BITS'(1);
         end
         OP_NACK: begin
            entry_in[0] = '{value: NACK_CODE, escape: 1'b1, closing: 1'b0};
            count_in    = ENTRY_BITS'(1);
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_comb begin
      item_valid_in = item_valid_ff;
      idx_in        = idx_ff;
      half_in       = half_ff;
      if (accept) begin
         item_valid_in = produce;
         idx_in        = '0;
         half_in       = 1'b0;
      end else if (load_out) begin
         if (item_done) begin
            item_valid_in = 1'b0;
         end
         if (entry_done) begin
            idx_in  = idx_ff + ENTRY_BITS'(1);
            half_in = 1'b0;
         end else begin
            half_in = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_close_in = rsp_close_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = item_done;
         rsp_close_in = cur.closing;
         if (!needs_esc) begin
            rsp_byte_in = cur.value;
         end else if (!half_ff) begin
            rsp_byte_in = ESC_MARK;
         end else if (cur.value == FRAME_MARK) begin
            rsp_byte_in = ESC_FRAME;
         end else begin
            rsp_byte_in = ESC_ESC;
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_open_ff <= 1'b0;
         remaining_ff  <= '0;
         sum_ff        <= '0;
         item_valid_ff <= 1'b0;
         count_ff      <= '0;
         idx_ff        <= '0;
         half_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (produce) begin
            frame_open_ff <= frame_open_in;
            remaining_ff  <= remaining_in;
            sum_ff        <= sum_in;
            count_ff      <= count_in;
         end
         item_valid_ff <= item_valid_in;
         idx_ff        <= idx_in;
         half_ff       <= half_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (produce) begin
         for (int i = 0; i < ENTRY_COUNT; i++) begin
            entry_ff[i] <= entry_in[i];
         end
      end
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_close_ff <= rsp_close_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_close_ff;

endmodule

>>> rtl/slip_checker.sv
// Port checker for the SLIP frame encoder and its bind to the top level.
module slip_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        rsp_tlast,
   input logic        rsp_tuser
);
   import slip_pkg::*;

   // The closing framing byte always ends the run of its transaction.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && rsp_tdata == FRAME_MARK)
      else $error("closing byte is not a final framing byte");

   // An escape byte is always followed by its second byte, so it never ends a run.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata == ESC_MARK |-> !rsp_tlast && !rsp_tuser)
      else $error("escape byte ends a run");

   // The output is empty after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("output valid after reset");

   // A stalled result transaction holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)
         && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

bind slip_frame_encoder slip_checker slip_checker_i (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

>>> tb/slip_frame_encoder_test.sv
// Self-checking testbench: directed and random transactions, line bytes checked against a local encoder model.
`timescale 1ns / 1ps

module slip_frame_encoder_test;
   import slip_pkg::*;

   localparam int HOLD_CYCLES  = 300;
   localparam int STALL_LIMIT  = 4000;
   localparam int PHASE_ITEMS  = 150;
   localparam int REPORT_LIMIT = 10;

   typedef struct {
      op_type     op;
      logic [7:0] channel;
      logic [15:0] length;
      logic [7:0] data;
   } request_type;

   typedef struct {
      logic [7:0] value;
      logic       run_end;
      logic       closed;
   } line_entry_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;

   request_type    pending[$];
   line_entry_type line_bytes_due[$];
   line_entry_type due;
   request_type    next_item;

   logic        frame_open = 1'b0;
   logic [15:0] bytes_left = '0;
   logic [15:0] frame_sum = '0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_armed = 1'b0;
   int hold_left = 0;
   int stall_cycles = 0;
   int mismatches = 0;
   int queued_items = 0;
   int frames_started = 0;
   int frames_closed = 0;
   int payload_bytes = 0;
   int dropped_bytes = 0;
   int escapes_seen = 0;
   int replies_sent = 0;
   int bytes_checked = 0;

   slip_frame_encoder i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   function automatic void push_line(logic [7:0] value, logic closed);
      line_entry_type e;
      e.value = value;
      e.run_end = 1'b0;
      e.closed = closed;
      line_bytes_due.push_back(e);
   endfunction

   function automatic void push_escaped(logic [7:0] value);
      if (value == FRAME_MARK) begin
         push_line(ESC_MARK, 1'b0);
         push_line(ESC_FRAME, 1'b0);
         escapes_seen++;
      end else if (value == ESC_MARK) begin
         push_line(ESC_MARK, 1'b0);
         push_line(ESC_ESC, 1'b0);
         escapes_seen++;
      end else begin
         push_line(value, 1'b0);
      end
   endfunction

   function automatic void close_frame();
      push_escaped(frame_sum[15:8]);
      push_escaped(frame_sum[7:0]);
      push_line(FRAME_MARK, 1'b1);
      frame_open = 1'b0;
      bytes_left = '0;
      frames_closed++;
   endfunction

   // Works out the line bytes that one accepted transaction must produce.
   function automatic void encode_item(logic [1:0] op_bits, logic [31:0] fields);
      int         size_before;
      logic [7:0] channel;
      logic [15:0] length;
      logic [7:0] data;
      size_before = line_bytes_due.size();
      channel = fields[7:0];
      length = fields[23:8];
      data = fields[31:24];
      case (op_type'(op_bits))
         OP_START: begin
            frames_started++;
            push_line(FRAME_MARK, 1'b0);
            push_escaped(channel);
            push_escaped(length[15:8]);
            push_escaped(length[7:0]);
            frame_sum = 16'(channel) + 16'(length[15:8]) + 16'(length[7:0]);
            if (length == 16'd0) begin
               close_frame();
            end else begin
               frame_open = 1'b1;
               bytes_left = length;
            end
         end
         OP_PAYLOAD: begin
            if (frame_open) begin
               payload_bytes++;
               push_escaped(data);
               frame_sum = frame_sum + 16'(data);
               bytes_left = bytes_left - 16'd1;
               if (bytes_left == 16'd0) close_frame();
            end else begin
               dropped_bytes++;
            end
         end
         OP_ACK: begin
            replies_sent++;
            push_escaped(ACK_CODE);
         end
         default: begin
            replies_sent++;
            push_escaped(NACK_CODE);
         end
      endcase
      if (line_bytes_due.size() > size_before)
         line_bytes_due[line_bytes_due.size() - 1].run_end = 1'b1;
   endfunction

   function automatic void add_item(op_type op, logic [7:0] channel, logic [15:0] length,
                                    logic [7:0] data);
      request_type r;
      r.op = op;
      r.channel = channel;
      r.length = length;
      r.data = data;
      pending.push_back(r);
      queued_items++;
   endfunction

   function automatic logic [7:0] pick_byte();
      int r;
      r = $urandom_range(99);
      if (r < 8) return FRAME_MARK;
      if (r < 16) return ESC_MARK;
      return 8'($urandom_range(255));
   endfunction

   // A well-formed frame, sometimes cut short or mixed with replies.
   function automatic void add_frame();
      int r;
      int length;
      int count;
      r = $urandom_range(99);
      if (r < 8) length = 0;
      else if (r < 14) length = $urandom_range(20, 40);
      else length = $urandom_range(1, 8);
      count = length;
      if (length > 0 && $urandom_range(99) < 8) count = $urandom_range(0, length - 1);
      add_item(OP_START, pick_byte(), 16'(length), 8'($urandom_range(255)));
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 10)
            add_item($urandom_range(1) ? OP_ACK : OP_NACK, pick_byte(),
                     16'($urandom_range(65535)), pick_byte());
         add_item(OP_PAYLOAD, 8'($urandom_range(255)), 16'($urandom_range(65535)), pick_byte());
      end
   endfunction

   function automatic void add_random_part();
      int target;
      target = queued_items + PHASE_ITEMS;
      while (queued_items < target) begin
         if ($urandom_range(99) < 88)
            add_frame();
         else
            add_item(op_type'($urandom_range(3)), 8'($urandom_range(255)),
                     16'($urandom_range(65535)), 8'($urandom_range(255)));
      end
   endfunction

   function automatic void add_directed_part();
      add_item(OP_ACK, 8'h00, 16'h0000, 8'h00);
      add_item(OP_NACK, 8'hFF, 16'hFFFF, 8'hFF);
      add_item(OP_PAYLOAD, 8'h00, 16'h0000, 8'hFF);
      add_item(OP_START, 8'h00, 16'h0000, 8'h00);
      add_item(OP_START, FRAME_MARK, 16'h0000, 8'h00);
      add_item(OP_START, ESC_MARK, 16'h0000, 8'h00);
      add_item(OP_START, 8'hFF, 16'hFFFF, 8'h00);
      add_item(OP_PAYLOAD, 8'h00, 16'h0000, FRAME_MARK);
      add_item(OP_START, FRAME_MARK, 16'hC0DB, 8'h00);
      add_item(OP_PAYLOAD, 8'hFF, 16'hFFFF, 8'hFF);
      add_item(OP_START, ESC_MARK, 16'h0004, 8'h00);
      add_item(OP_PAYLOAD, 8'h00, 16'h0000, 8'h00);
      add_item(OP_ACK, 8'h00, 16'h0000, 8'h00);
      add_item(OP_PAYLOAD, 8'h00, 16'h0000, 8'hFF);
      add_item(OP_NACK, 8'h00, 16'h0000, 8'h00);
      add_item(OP_PAYLOAD, 8'h00, 16'h0000, ESC_MARK);
      add_item(OP_PAYLOAD, 8'h00, 16'h0000, FRAME_MARK);
      add_item(OP_PAYLOAD, 8'h00, 16'h0000, 8'h55);
      add_item(OP_START, 8'h01, 16'h0001, 8'h00);
      add_item(OP_PAYLOAD, 8'h00, 16'h0000, 8'hBE);
   endfunction

   task automatic drain();
      do @(negedge clock);
      while (pending.size() != 0 || req_tvalid || line_bytes_due.size() != 0);
      repeat (12) @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) encode_item(req_tuser, req_tdata);
         if (!req_tvalid || req_tready) begin
            if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_item = pending.pop_front();
               req_tdata <= {next_item.data, next_item.length, next_item.channel};
               req_tuser <= next_item.op;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_armed && hold_left < HOLD_CYCLES) begin
         hold_left <= hold_left + 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         bytes_checked++;
         if (line_bytes_due.size() == 0) begin
            if (mismatches < REPORT_LIMIT)
               $display("%0t: unexpected line byte %0d last %0b closed %0b", $realtime,
                        rsp_tdata, rsp_tlast, rsp_tuser);
            mismatches++;
         end else begin
            due = line_bytes_due.pop_front();
            if (rsp_tdata !== due.value || rsp_tlast !== due.run_end ||
                rsp_tuser !== due.closed) begin
               if (mismatches < REPORT_LIMIT)
                  $display("%0t: expected byte %0d last %0b closed %0b, got %0d %0b %0b",
                           $realtime, due.value, due.run_end, due.closed,
                           rsp_tdata, rsp_tlast, rsp_tuser);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
         $display("Verification failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      send_idle_pct = 15;
      recv_idle_pct = 50;
      add_directed_part();
      add_random_part();
      drain();

      send_idle_pct = 50;
      recv_idle_pct = 15;
      add_random_part();
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_armed = 1'b1;
      add_random_part();
      drain();

      repeat (20) @(posedge clock);
      $display("Covered %0d transactions: %0d frames opened, %0d closed, %0d payload bytes",
               queued_items, frames_started, frames_closed, payload_bytes);
      $display("%0d stray bytes dropped, %0d replies, %0d escapes, %0d line bytes checked",
               dropped_bytes, replies_sent, escapes_seen, bytes_checked);
      if (mismatches == 0 && line_bytes_due.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches, %0d line bytes never seen", mismatches,
                  line_bytes_due.size());
         $display("Verification failed");
      end
      $finish;
   end

endmodule
